// ===== sv/cbc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the contour blob classifier.
// No dependencies; used by cbc_area, contour_blob_classifier_core and the bench.
package cbc_pkg;

    localparam int AREA_BITS   = 21;
    localparam int SUM_BITS    = 48;
    localparam int MIN_BITS    = 13;
    localparam int MAX_BITS    = 14;
    localparam int ASPECT_BITS = 9;
    localparam int CFG_BITS    = 14;
    localparam int CFG_IDX_BITS = 2;
    localparam int PCT_BITS    = 7;

    localparam logic [PCT_BITS-1:0]    PCT_SCALE      = 7'd100;
    localparam logic [MIN_BITS-1:0]    MIN_AREA_RST   = 13'd500;
    localparam logic [MAX_BITS-1:0]    MAX_AREA_RST   = 14'd1000;
    localparam logic [ASPECT_BITS-1:0] ASPECT_PCT_RST = 9'd100;

    localparam logic [SUM_BITS-1:0] AREA_CAP =
        {{(SUM_BITS-AREA_BITS){1'b0}}, {AREA_BITS{1'b1}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MIN_AREA   = 2'd0,
        REG_MAX_AREA   = 2'd1,
        REG_ASPECT_PCT = 2'd2
    } cfg_reg_t;

    // Control that travels with each beat down the pipeline.
    typedef struct packed {
        logic valid;
        logic start;
        logic last;
    } beat_ctl_t;

    // Doubled area of the full coordinate square, capped to the result field.
    function automatic logic [SUM_BITS-1:0] area_limit(input int cb);
        logic [SUM_BITS-1:0] cmax;
        logic [SUM_BITS-1:0] raw;
        cmax = (SUM_BITS'(1) << cb) - SUM_BITS'(1);
        raw  = (cmax * cmax) << 1;
        return (raw > AREA_CAP) ? AREA_CAP : raw;
    endfunction

endpackage

// ===== sv/contour_blob_classifier_core.sv =====
`timescale 1ns / 1ps
// Top level of the contour blob classifier: input stage, bounding box,
// person test and output register. Depends on cbc_pkg and cbc_area.
//
// Usage:
// The input channel carries one contour point per beat (point_x, point_y,
// last_point). A contour is every beat up to and including the one with
// last_point set; the next beat starts a new contour. For each contour the
// output channel carries exactly one beat: twice the absolute polygon area
// (saturated), the bounding box width and height, and the person flag.
// Points that are not last produce no output beat.
//
// Throughput is one point per clock cycle while in_stall is low. The path is
// a fixed six-stage pipeline: input register, cross products and box update,
// edge delta, accumulator, magnitude and aspect products, then the output
// register. A contour's result reaches out_valid once its last point has passed
// through stages 1 to 5 and into the output register.
//
// When the receiver holds out_stall, the output beat stays put and the
// pipeline keeps taking points until a finished result reaches the stage
// just before the output register; only then is in_stall raised.
// Reset clears all contour state and all valid bits, and loads the threshold
// registers with 500, 1000 and 100. The user must write threshold registers
// through cfg_write, cfg_index and cfg_data only while idle; the core does not check.
module contour_blob_classifier_core #(
    parameter int COORD_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [COORD_BITS-1:0]            point_x,
    input  logic [COORD_BITS-1:0]            point_y,
    input  logic                             last_point,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             is_person,
    output logic [cbc_pkg::AREA_BITS-1:0]    area_doubled,
    output logic [COORD_BITS-1:0]            box_width,
    output logic [COORD_BITS-1:0]            box_height,
    input  logic                             cfg_write,
    input  logic [cbc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cbc_pkg::CFG_BITS-1:0]     cfg_data
);
    import cbc_pkg::*;

    localparam int PCT_PROD_BITS = COORD_BITS + PCT_BITS;
    localparam int ASP_PROD_BITS = COORD_BITS + ASPECT_BITS;
    localparam logic [SUM_BITS-1:0] AREA_LIM = area_limit(COORD_BITS);

    // Threshold registers.
    logic [MIN_BITS-1:0]    min_area_reg;
    logic [MAX_BITS-1:0]    max_area_reg;
    logic [ASPECT_BITS-1:0] aspect_pct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_area_reg   <= MIN_AREA_RST;
            max_area_reg   <= MAX_AREA_RST;
            aspect_pct_reg <= ASPECT_PCT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MIN_AREA:   min_area_reg   <= cfg_data[MIN_BITS-1:0];
                REG_MAX_AREA:   max_area_reg   <= cfg_data[MAX_BITS-1:0];
                REG_ASPECT_PCT: aspect_pct_reg <= cfg_data[ASPECT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // The whole pipeline moves together. It only halts when the output
    // register is blocked and a finished result is waiting right behind it.
    logic      adv;
    beat_ctl_t s5_ctl;
    logic      out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall && s5_ctl.valid && s5_ctl.last);
    assign in_stall = !adv;

    logic accept;
    assign accept = in_valid && adv;

    // Contour tracking: whether a contour is open, its first and previous point.
    logic                  in_contour_reg;
    logic [COORD_BITS-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;

    // Stage 1: input register.
    beat_ctl_t             s1_ctl_reg;
    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg, s1_px_reg, s1_py_reg, s1_fx_reg, s1_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_contour_reg <= 1'b0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            s1_ctl_reg     <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg.valid <= in_valid;
            s1_ctl_reg.start <= !in_contour_reg;
            s1_ctl_reg.last  <= last_point;
            if (accept)
            begin
                in_contour_reg <= !last_point;
                prev_x_reg     <= point_x;
                prev_y_reg     <= point_y;
                if (!in_contour_reg)
                begin
                    first_x_reg <= point_x;
                    first_y_reg <= point_y;
                end
            end
        end
    end

    // On the first point of a contour the point itself stands in for the
    // first point, so a one-point contour closes onto itself with zero area.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg  <= point_x;
            s1_y_reg  <= point_y;
            s1_px_reg <= prev_x_reg;
            s1_py_reg <= prev_y_reg;
            s1_fx_reg <= in_contour_reg ? first_x_reg : point_x;
            s1_fy_reg <= in_contour_reg ? first_y_reg : point_y;
        end
    end

    // Area path, stages 2 through 5.
    logic [AREA_BITS-1:0] mag;

    cbc_area #(
        .COORD_BITS (COORD_BITS)
    ) u_area (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .s1_ctl (s1_ctl_reg),
        .x      (s1_x_reg),
        .y      (s1_y_reg),
        .px     (s1_px_reg),
        .py     (s1_py_reg),
        .fx     (s1_fx_reg),
        .fy     (s1_fy_reg),
        .s5_ctl (s5_ctl),
        .mag    (mag)
    );

    // Stage 2: bounding box. A new contour reloads the box from its first point.
    logic [COORD_BITS-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic [COORD_BITS-1:0] lo_x_next, hi_x_next, lo_y_next, hi_y_next;

    always_comb
    begin
        if (s1_ctl_reg.start)
        begin
            lo_x_next = s1_x_reg;
            hi_x_next = s1_x_reg;
            lo_y_next = s1_y_reg;
            hi_y_next = s1_y_reg;
        end
        else
        begin
            lo_x_next = (s1_x_reg < lo_x_reg) ? s1_x_reg : lo_x_reg;
            hi_x_next = (s1_x_reg > hi_x_reg) ? s1_x_reg : hi_x_reg;
            lo_y_next = (s1_y_reg < lo_y_reg) ? s1_y_reg : lo_y_reg;
            hi_y_next = (s1_y_reg > hi_y_reg) ? s1_y_reg : hi_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_x_reg <= '1;
            hi_x_reg <= '0;
            lo_y_reg <= '1;
            hi_y_reg <= '0;
        end
        else if (adv && s1_ctl_reg.valid)
        begin
            lo_x_reg <= lo_x_next;
            hi_x_reg <= hi_x_next;
            lo_y_reg <= lo_y_next;
            hi_y_reg <= hi_y_next;
        end
    end

    // Box size rides alongside the area path so it meets the area at stage 5.
    // Stage 5 also forms both sides of the aspect comparison.
    logic [COORD_BITS-1:0]    dx2_reg, dy2_reg, dx3_reg, dy3_reg, dx4_reg, dy4_reg;
    logic [COORD_BITS-1:0]    dx5_reg, dy5_reg;
    logic [PCT_PROD_BITS-1:0] pct_dy5_reg;
    logic [ASP_PROD_BITS-1:0] asp_dx5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx2_reg     <= hi_x_next - lo_x_next;
            dy2_reg     <= hi_y_next - lo_y_next;
            dx3_reg     <= dx2_reg;
            dy3_reg     <= dy2_reg;
            dx4_reg     <= dx3_reg;
            dy4_reg     <= dy3_reg;
            dx5_reg     <= dx4_reg;
            dy5_reg     <= dy4_reg;
            pct_dy5_reg <= PCT_PROD_BITS'(dy4_reg) * PCT_PROD_BITS'(PCT_SCALE);
            asp_dx5_reg <= ASP_PROD_BITS'(dx4_reg) * ASP_PROD_BITS'(aspect_pct_reg);
        end
    end

    // Person test. The area bounds are doubled to compare against the doubled area.
    logic person_next;

    always_comb
    begin
        logic area_ok;
        logic aspect_ok;
        area_ok   = (mag > AREA_BITS'({min_area_reg, 1'b0}))
                 && (mag < AREA_BITS'({max_area_reg, 1'b0}));
        aspect_ok = (dx5_reg != '0)
                 && (ASP_PROD_BITS'(pct_dy5_reg) > asp_dx5_reg);
        person_next = area_ok && aspect_ok;
    end

    // Stage 6: output register.
    logic                  is_person_reg;
    logic [AREA_BITS-1:0]  area_reg;
    logic [COORD_BITS-1:0] box_w_reg, box_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && s5_ctl.valid && s5_ctl.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s5_ctl.valid && s5_ctl.last)
        begin
            is_person_reg <= person_next;
            area_reg      <= mag;
            box_w_reg     <= dx5_reg;
            box_h_reg     <= dy5_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_person    = is_person_reg;
    assign area_doubled = area_reg;
    assign box_width    = box_w_reg;
    assign box_height   = box_h_reg;

    // The input only backs up behind a blocked result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // A result appears only after a last point has reached stage 5.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s5_ctl.valid && s5_ctl.last))
        else $error("result without a closing point");

    // A person needs a box of nonzero width.
    a_person_width: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_person) |-> (box_width != '0))
        else $error("person flagged on a zero-width box");

    // The area never exceeds its saturation limit.
    a_area_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (SUM_BITS'(area_doubled) <= AREA_LIM))
        else $error("area above saturation limit");

endmodule

// ===== sv/cbc_area.sv =====
`timescale 1ns / 1ps
// Shoelace area pipeline: cross products, running sum, magnitude and saturation.
// Depends on cbc_pkg.
module cbc_area #(
    parameter int COORD_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  cbc_pkg::beat_ctl_t            s1_ctl,
    input  logic [COORD_BITS-1:0]         x,
    input  logic [COORD_BITS-1:0]         y,
    input  logic [COORD_BITS-1:0]         px,
    input  logic [COORD_BITS-1:0]         py,
    input  logic [COORD_BITS-1:0]         fx,
    input  logic [COORD_BITS-1:0]         fy,
    output cbc_pkg::beat_ctl_t            s5_ctl,
    output logic [cbc_pkg::AREA_BITS-1:0] mag
);
    import cbc_pkg::*;

    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int DELTA_BITS = PROD_BITS + 2;
    localparam logic [SUM_BITS-1:0] AREA_LIM = area_limit(COORD_BITS);

    beat_ctl_t ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [PROD_BITS-1:0] p_open_a_reg, p_open_b_reg, p_close_a_reg, p_close_b_reg;
    logic signed [DELTA_BITS-1:0] delta_reg, delta_next;
    logic [SUM_BITS-1:0] acc_reg, sum_next, sum4_reg, mag_wide;
    logic [AREA_BITS-1:0] mag_reg, mag_next;

    // The edge from the previous point and the closing edge back to the first point.
    always_comb
    begin
        logic signed [DELTA_BITS-1:0] d_open;
        logic signed [DELTA_BITS-1:0] d_close;
        d_open  = ctl2_reg.start ? '0 :
                  $signed(DELTA_BITS'(p_open_a_reg)) - $signed(DELTA_BITS'(p_open_b_reg));
        d_close = ctl2_reg.last ?
                  $signed(DELTA_BITS'(p_close_a_reg)) - $signed(DELTA_BITS'(p_close_b_reg)) :
                  '0;
        delta_next = d_open + d_close;
    end

    assign sum_next = (ctl3_reg.start ? '0 : acc_reg)
                    + {{(SUM_BITS-DELTA_BITS){delta_reg[DELTA_BITS-1]}}, delta_reg};

    assign mag_wide = sum4_reg[SUM_BITS-1] ? (SUM_BITS'(0) - sum4_reg) : sum4_reg;
    assign mag_next = (mag_wide > AREA_LIM) ? AREA_LIM[AREA_BITS-1:0]
                                            : mag_wide[AREA_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            acc_reg  <= '0;
        end
        else if (adv)
        begin
            ctl2_reg <= s1_ctl;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            if (ctl3_reg.valid)
            begin
                acc_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_open_a_reg  <= PROD_BITS'(px) * PROD_BITS'(y);
            p_open_b_reg  <= PROD_BITS'(x) * PROD_BITS'(py);
            p_close_a_reg <= PROD_BITS'(x) * PROD_BITS'(fy);
            p_close_b_reg <= PROD_BITS'(fx) * PROD_BITS'(y);
            delta_reg     <= delta_next;
            sum4_reg      <= sum_next;
            mag_reg       <= mag_next;
        end
    end

    assign s5_ctl = ctl5_reg;
    assign mag    = mag_reg;

endmodule

// ===== bench/cbc_blob_checker.sv =====
`timescale 1ns / 1ps
// Checker for contour_blob_classifier_core. It follows the accepted point beats,
// works out each contour's blob result and compares it with the output beats.
// Depends on cbc_pkg.
module cbc_blob_checker #(
    parameter int COORD_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [COORD_BITS-1:0]            point_x,
    input  logic [COORD_BITS-1:0]            point_y,
    input  logic                             last_point,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             is_person,
    input  logic [cbc_pkg::AREA_BITS-1:0]    area_doubled,
    input  logic [COORD_BITS-1:0]            box_width,
    input  logic [COORD_BITS-1:0]            box_height,
    input  logic                             cfg_write,
    input  logic [cbc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [cbc_pkg::CFG_BITS-1:0]     cfg_data,
    output int                               error_count,
    output int                               open_blobs
);
    import cbc_pkg::*;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SUM_BITS-1:0]   wide_t;

    typedef struct {
        logic                 person;
        logic [AREA_BITS-1:0] area2;
        coord_t               width;
        coord_t               height;
    } blob_t;

    // The doubled area saturates at twice the largest square, and never beyond the field.
    localparam wide_t SIDE_MAX   = (wide_t'(1) << COORD_BITS) - wide_t'(1);
    localparam wide_t FIELD_MAX  = (wide_t'(1) << AREA_BITS) - wide_t'(1);
    localparam wide_t SQUARE_TOP = (SIDE_MAX * SIDE_MAX) << 1;
    localparam wide_t AREA_CEIL  = (SQUARE_TOP > FIELD_MAX) ? FIELD_MAX : SQUARE_TOP;

    blob_t due_blobs[$];

    logic [MIN_BITS-1:0]    min_area_r;
    logic [MAX_BITS-1:0]    max_area_r;
    logic [ASPECT_BITS-1:0] aspect_r;

    logic   tracing;
    coord_t first_x, first_y, prev_x, prev_y;
    coord_t lo_x, hi_x, lo_y, hi_y;
    wide_t  shoelace;

    function automatic wide_t edge_cross(coord_t xa, coord_t ya, coord_t xb, coord_t yb);
        return wide_t'(xa) * wide_t'(yb) - wide_t'(xb) * wide_t'(ya);
    endfunction

    task automatic clear_contour();
        tracing  = 1'b0;
        first_x  = '0;
        first_y  = '0;
        prev_x   = '0;
        prev_y   = '0;
        lo_x     = '1;
        hi_x     = '0;
        lo_y     = '1;
        hi_y     = '0;
        shoelace = '0;
    endtask

    task automatic follow_point(coord_t x, coord_t y, logic is_last);
        wide_t  total;
        wide_t  mag;
        coord_t w;
        coord_t h;
        blob_t  blob;
        if (!tracing)
        begin
            tracing  = 1'b1;
            first_x  = x;
            first_y  = y;
            lo_x     = x;
            hi_x     = x;
            lo_y     = y;
            hi_y     = y;
            shoelace = '0;
        end
        else
        begin
            shoelace = shoelace + edge_cross(prev_x, prev_y, x, y);
            if (x < lo_x) lo_x = x;
            if (x > hi_x) hi_x = x;
            if (y < lo_y) lo_y = y;
            if (y > hi_y) hi_y = y;
        end
        prev_x = x;
        prev_y = y;
        if (is_last)
        begin
            // Close the polygon from the final point back to the first one.
            total = shoelace + edge_cross(x, y, first_x, first_y);
            mag   = total[SUM_BITS-1] ? -total : total;
            if (mag > AREA_CEIL) mag = AREA_CEIL;
            w = hi_x - lo_x;
            h = hi_y - lo_y;
            blob.person = (mag > (wide_t'(min_area_r) << 1)) &&
                          (mag < (wide_t'(max_area_r) << 1)) && (w != '0) &&
                          (32'(PCT_SCALE) * 32'(h) > 32'(aspect_r) * 32'(w));
            blob.area2  = mag[AREA_BITS-1:0];
            blob.width  = w;
            blob.height = h;
            due_blobs.insert(due_blobs.size(), blob);
            clear_contour();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blob_t want;
        if (!rst_n)
        begin
            min_area_r = MIN_AREA_RST;
            max_area_r = MAX_AREA_RST;
            aspect_r   = ASPECT_PCT_RST;
            clear_contour();
            due_blobs.delete();
            error_count = 0;
            open_blobs  = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MIN_AREA:   min_area_r = cfg_data[MIN_BITS-1:0];
                    REG_MAX_AREA:   max_area_r = cfg_data[MAX_BITS-1:0];
                    REG_ASPECT_PCT: aspect_r   = cfg_data[ASPECT_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                follow_point(point_x, point_y, last_point);
            if (out_valid && !out_stall)
            begin
                if (due_blobs.size() == 0)
                begin
                    $error("result beat with no finished contour waiting");
                    error_count++;
                end
                else
                begin
                    want = due_blobs.pop_front();
                    if (is_person !== want.person)
                    begin
                        $error("is_person: expected %0d, actual %0d", want.person, is_person);
                        error_count++;
                    end
                    if (area_doubled !== want.area2)
                    begin
                        $error("area_doubled: expected %0d, actual %0d",
                               want.area2, area_doubled);
                        error_count++;
                    end
                    if (box_width !== want.width)
                    begin
                        $error("box_width: expected %0d, actual %0d", want.width, box_width);
                        error_count++;
                    end
                    if (box_height !== want.height)
                    begin
                        $error("box_height: expected %0d, actual %0d",
                               want.height, box_height);
                        error_count++;
                    end
                end
            end
            open_blobs = due_blobs.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the contour blob classifier bench: clock, reset, point and threshold
// stimulus and the final verdict. Depends on cbc_pkg, cbc_blob_checker and the core.
module tb_top;
    import cbc_pkg::*;

    localparam int COORD_BITS   = 10;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    // The core is a six-stage pipeline, and the drain after each phase covers anything in flight.
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 7;
    localparam int PHASE_POINTS = 240;

    // Index 3 decodes to no register; writing it must leave every threshold alone.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    // Percent chance of an idle burst on the point side and the result side, per phase.
    // The final phase runs with no idling at all.
    localparam int GAP_PLAN[PHASES]   = '{0, 15, 40, 5, 25, 60, 0};
    localparam int STALL_PLAN[PHASES] = '{30, 0, 40, 10, 60, 20, 0};

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t x;
        coord_t y;
    } point_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_stall;
    coord_t                  point_x    = '0;
    coord_t                  point_y    = '0;
    logic                    last_point = 1'b0;
    logic                    out_valid;
    logic                    out_stall  = 1'b0;
    logic                    is_person;
    logic [AREA_BITS-1:0]    area_doubled;
    coord_t                  box_width;
    coord_t                  box_height;
    logic                    cfg_write  = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index  = '0;
    logic [CFG_BITS-1:0]     cfg_data   = '0;

    int fail_count;
    int open_blobs;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int sent_points = 0;
    int cycle_count = 0;

    // Points of the contour that is being assembled before it is sent.
    point_t path[$];

    always #5 clk = ~clk;

    contour_blob_classifier_core #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_person   (is_person),
        .area_doubled(area_doubled),
        .box_width   (box_width),
        .box_height  (box_height),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    cbc_blob_checker #(
        .COORD_BITS(COORD_BITS)
    ) blob_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_person   (is_person),
        .area_doubled(area_doubled),
        .box_width   (box_width),
        .box_height  (box_height),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (fail_count),
        .open_blobs  (open_blobs)
    );

    // A hung handshake must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The result side holds off in random bursts. Each burst ends by lowering out_stall,
    // so a waiting result beat always gets through eventually.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic add_point(int x, int y);
        point_t pt;
        pt.x = coord_t'(x);
        pt.y = coord_t'(y);
        path.insert(path.size(), pt);
    endtask

    // Offers one point beat and holds it until the core takes it. Entered and left
    // at a falling edge. An idle burst, when one is drawn, comes before the beat,
    // so valid is never lowered and raised in the same step.
    task automatic send_point(coord_t x, coord_t y, logic is_last);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        point_x    <= x;
        point_y    <= y;
        last_point <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        sent_points++;
    endtask

    // Sends the assembled path as one contour; its final point carries the last flag.
    task automatic send_path();
        for (int i = 0; i < path.size(); i++)
            send_point(path[i].x, path[i].y, i == path.size() - 1);
        path.delete();
    endtask

    // Traces an axis-aligned rectangle from a random corner in a random direction.
    // Extra points halfway along some edges are collinear, so the area is unchanged.
    task automatic rect_path(int x0, int y0, int w, int h);
        int cx[4];
        int cy[4];
        int start;
        int dir;
        int a;
        int b;
        cx    = '{x0, x0 + w, x0 + w, x0};
        cy    = '{y0, y0, y0 + h, y0 + h};
        start = $urandom_range(0, 3);
        dir   = $urandom_range(0, 1) ? 1 : 3;
        for (int k = 0; k < 4; k++)
        begin
            a = (start + k * dir) % 4;
            b = (a + dir) % 4;
            add_point(cx[a], cy[a]);
            if ($urandom_range(0, 2) == 0)
                add_point((cx[a] + cx[b]) / 2, (cy[a] + cy[b]) / 2);
        end
    endtask

    // One random contour. Small rectangles dominate, since their areas land around
    // the thresholds; the rest are clustered polygons, one- and two-point contours,
    // large rectangles and scattered full-range points for large areas.
    task automatic random_contour();
        int kind;
        int w;
        int h;
        int span;
        int ox;
        int oy;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 64);
            rect_path($urandom_range(0, COORD_MAX - w), $urandom_range(0, COORD_MAX - h), w, h);
        end
        else if (kind < 70)
        begin
            span = $urandom_range(8, 80);
            ox   = $urandom_range(0, COORD_MAX - span);
            oy   = $urandom_range(0, COORD_MAX - span);
            repeat ($urandom_range(3, 8))
                add_point(ox + $urandom_range(0, span), oy + $urandom_range(0, span));
        end
        else if (kind < 80)
        begin
            // A vertical pair has height but no width.
            ox = $urandom_range(0, COORD_MAX);
            oy = $urandom_range(0, COORD_MAX);
            add_point(ox, oy);
            case ($urandom_range(0, 2))
                0: ;
                1: add_point(ox, $urandom_range(0, COORD_MAX));
                default: add_point($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            endcase
        end
        else if (kind < 90)
        begin
            w = $urandom_range(1, COORD_MAX);
            h = $urandom_range(1, COORD_MAX);
            rect_path($urandom_range(0, COORD_MAX - w), $urandom_range(0, COORD_MAX - h), w, h);
        end
        else
        begin
            repeat ($urandom_range(3, 12))
                add_point($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        end
        send_path();
    endtask

    // Drops valid and waits until every finished contour has come out, then lets the
    // pipeline run empty, so thresholds can be written safely afterwards.
    task automatic settle();
        in_valid <= 1'b0;
        while (open_blobs != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int phase_end;
        int lo;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed contours under the reset thresholds.
        stall_pct = 20;
        // Lone points at both corners of the coordinate range.
        add_point(0, 0);
        send_path();
        add_point(COORD_MAX, COORD_MAX);
        send_path();
        // A two-point contour has no area but spans the whole box.
        add_point(0, 0);
        add_point(COORD_MAX, COORD_MAX);
        send_path();
        // A vertical segment: full height, zero width, so never a person.
        add_point(5, 0);
        add_point(5, COORD_MAX);
        send_path();
        // Tall 20 by 40 rectangle, counterclockwise: area 800 is a person.
        add_point(10, 10);
        add_point(30, 10);
        add_point(30, 50);
        add_point(10, 50);
        send_path();
        // Area of exactly 500 sits on the lower bound and fails it.
        add_point(100, 200);
        add_point(120, 200);
        add_point(120, 225);
        add_point(100, 225);
        send_path();
        // The whole frame, clockwise: a negative sum that lands exactly on the cap.
        add_point(0, 0);
        add_point(0, COORD_MAX);
        add_point(COORD_MAX, COORD_MAX);
        add_point(COORD_MAX, 0);
        send_path();
        // Going round the frame one and a half times overshoots the cap.
        add_point(0, 0);
        add_point(COORD_MAX, 0);
        add_point(COORD_MAX, COORD_MAX);
        add_point(0, COORD_MAX);
        add_point(0, 0);
        add_point(COORD_MAX, 0);
        add_point(COORD_MAX, COORD_MAX);
        send_path();
        settle();

        // Random phases. Every phase ends with a full drain before the thresholds move.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // Widest window and no aspect demand: most boxes with height pass.
                    write_reg(REG_MIN_AREA, '0);
                    write_reg(REG_MAX_AREA, '1);
                    write_reg(REG_ASPECT_PCT, '0);
                end
                1:
                begin
                    // Min and aspect all-ones, masked; max zero; spare index ignored.
                    write_reg(REG_MIN_AREA, '1);
                    write_reg(REG_MAX_AREA, '0);
                    write_reg(REG_ASPECT_PCT, '1);
                    write_reg(REG_SPARE, 14'h1555);
                end
                2:
                begin
                    write_reg(REG_MIN_AREA, 14'd5000);
                    write_reg(REG_MAX_AREA, 14'd10000);
                    write_reg(REG_ASPECT_PCT, 14'd500);
                end
                default:
                begin
                    lo = $urandom_range(0, 2500);
                    write_reg(REG_MIN_AREA, CFG_BITS'(lo));
                    write_reg(REG_MAX_AREA, CFG_BITS'(lo + $urandom_range(0, 4000)));
                    write_reg(REG_ASPECT_PCT, CFG_BITS'($urandom_range(0, 500)));
                end
            endcase
            gap_pct   = GAP_PLAN[p];
            stall_pct = STALL_PLAN[p];
            phase_end = sent_points + PHASE_POINTS;
            while (sent_points < phase_end)
                random_contour();
            settle();
        end

        if (fail_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
